[rtl/core/tvcs_pkg.sv]
`default_nettype none
package tvcs_pkg;

  // shared multiplier operand width
  localparam int unsigned MulW = 32;

  // sweep deltas in Q48
  localparam logic [35:0] DownDelta = 36'd44237699430;
  localparam logic [35:0] UpDelta   = 36'd20646639365;

  // reciprocals: floor(x/1764) = (x*EnvRecip)>>32, floor(y/10000) = (y*RndRecip)>>45,
  // floor(y/25) = (y*Div25Recip)>>32
  localparam logic [31:0] EnvRecip   = 32'd2434789;
  localparam logic [31:0] RndRecip   = 32'd3518437209;
  localparam logic [31:0] Div25Recip = 32'd171798692;
  localparam logic [31:0] MixGain    = 32'd720874;   // 22 * 32767
  localparam logic [28:0] RndHalf    = 29'd5000;
  localparam logic [15:0] PcmMax     = 16'd32767;

  // waveform codes
  localparam logic [1:0] WaveSquare = 2'd0;
  localparam logic [1:0] WaveTri    = 2'd1;
  localparam logic [1:0] WaveNoise  = 2'd2;

  // sweep codes
  localparam logic [1:0] SweepDown = 2'd1;
  localparam logic [1:0] SweepUp   = 2'd2;

  // register indexes
  typedef enum logic [2:0] {
    RegV0Wave   = 3'd0,
    RegV1Wave   = 3'd1,
    RegV0Sweep  = 3'd2,
    RegV1Sweep  = 3'd3,
    RegV0Short  = 3'd4,
    RegV1Short  = 3'd5,
    RegV1Enable = 3'd6
  } reg_idx_e;

  // increment for the lowest octave, per semitone
  function automatic logic [63:0] octave_base(input logic [3:0] semi);
    logic [63:0] r;
    begin
      case (semi)
        4'd0:    r = 64'd104366567318;
        4'd1:    r = 64'd110572526359;
        4'd2:    r = 64'd117147510927;
        4'd3:    r = 64'd124113464424;
        4'd4:    r = 64'd131493635070;
        4'd5:    r = 64'd139312653500;
        4'd6:    r = 64'd147596614960;
        4'd7:    r = 64'd156373166403;
        4'd8:    r = 64'd165671598752;
        4'd9:    r = 64'd175522944661;
        4'd10:   r = 64'd185960082081;
        4'd11:   r = 64'd197017843989;
        default: r = 64'd104366567318;
      endcase
      return r;
    end
  endfunction

  // triangle level magnitude for step value t (negative below 8)
  function automatic logic [15:0] tri_mag(input logic [3:0] t);
    logic [15:0] r;
    begin
      case (t)
        4'd0, 4'd15: r = 16'd32768;
        4'd1, 4'd14: r = 16'd28399;
        4'd2, 4'd13: r = 16'd24030;
        4'd3, 4'd12: r = 16'd19661;
        4'd4, 4'd11: r = 16'd15292;
        4'd5, 4'd10: r = 16'd10923;
        4'd6, 4'd9:  r = 16'd6554;
        default:     r = 16'd2185;
      endcase
      return r;
    end
  endfunction

  function automatic logic [6:0] vol_pct(input logic [2:0] code);
    logic [6:0] r;
    begin
      case (code)
        3'd0:    r = 7'd100;
        3'd1:    r = 7'd70;
        3'd2:    r = 7'd60;
        3'd3:    r = 7'd55;
        default: r = 7'd50;
      endcase
      return r;
    end
  endfunction

  // envelope percent lost per step
  function automatic logic [4:0] env_rate(input logic [1:0] env);
    logic [4:0] r;
    begin
      case (env)
        2'd1:    r = 5'd10;
        2'd2:    r = 5'd3;
        2'd3:    r = 5'd25;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/two_voice_chiptune_sample_synth_top.sv]
// From item acceptance to out_valid_o: each voice goes through S_PREP, where a resting
// voice ends; a playing voice goes on through S_ENV, S_AMP and S_DIV, plus S_SW1 to S_SW4
// and S_SWFIN with pitch sweep; then the mix runs S_MIX, S_MIXA and S_MIXB to S_OUT.
// No new item is taken before the sample is delivered; all work runs through a single
// registered 32x32 multiplier, so in_stall_o is high from acceptance to delivery.
// Reset (rst_ni low, asynchronous): control and voice registers cleared, noise registers all ones.
`default_nettype none
module two_voice_chiptune_sample_synth_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              effect_start_i,
  input  wire logic              v0_new_note_i,
  input  wire logic signed [7:0] v0_note_i,
  input  wire logic [1:0]        v0_duty_i,
  input  wire logic [1:0]        v0_env_i,
  input  wire logic [2:0]        v0_volume_i,
  input  wire logic              v1_new_note_i,
  input  wire logic signed [7:0] v1_note_i,
  input  wire logic [1:0]        v1_duty_i,
  input  wire logic [1:0]        v1_env_i,
  input  wire logic [2:0]        v1_volume_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [15:0]     pcm_sample_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [1:0]        cfg_data_i
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PREP  = 14'b00000000000010,
    S_ENV   = 14'b00000000000100,
    S_AMP   = 14'b00000000001000,
    S_DIV   = 14'b00000000010000,
    S_SW1   = 14'b00000000100000,
    S_SW2   = 14'b00000001000000,
    S_SW3   = 14'b00000010000000,
    S_SW4   = 14'b00000100000000,
    S_SWFIN = 14'b00001000000000,
    S_MIX   = 14'b00010000000000,
    S_MIXA  = 14'b00100000000000,
    S_MIXB  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  typedef struct packed {
    logic       new_note;
    logic [7:0] note;
    logic [1:0] duty;
    logic [1:0] env;
    logic [2:0] vol;
  } voice_in_t;

  state_e state_q;
  logic   vsel_q;

  // configuration
  logic [1:0] wave_q [2];
  logic [1:0] sweep_q [2];
  logic       short_q [2];
  logic       v1_en_q;

  // voice state
  logic [47:0] phase_q [2];
  logic [63:0] step_q [2];
  logic [15:0] cnt_q [2];
  logic [14:0] lfsr_q [2];

  // per-item working registers
  voice_in_t         vin_q [2];
  logic [15:0]       w_mag_q;
  logic              w_neg_q;
  logic signed [17:0] mix_q;
  logic [99:0]       acc_q;
  logic signed [15:0] pcm_q;

  // shared multiplier
  logic [tvcs_pkg::MulW-1:0]   mul_a, mul_b;
  logic [2*tvcs_pkg::MulW-1:0] prod;

  tvcs_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // handshakes
  logic in_acc, out_acc;
  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign out_acc      = out_valid_o && !out_stall_i;
  assign pcm_sample_o = pcm_q;
  assign cfg_ready_o  = 1'b1;

  // current voice view
  voice_in_t   vc;
  logic [15:0] cnt_eff, cnt_sat, cnt_eff_sat;
  logic [63:0] step_eff, step_load;
  logic [14:0] note_x171;
  logic [3:0]  octave, semi;
  logic        last_voice;
  logic [1:0]  wave_c, sweep_c;
  logic        sweeping;

  always_comb begin
    vc          = vin_q[vsel_q];
    cnt_eff     = vc.new_note ? 16'd0 : cnt_q[vsel_q];
    step_eff    = vc.new_note ? 64'd0 : step_q[vsel_q];
    cnt_eff_sat = (cnt_eff == 16'hffff) ? cnt_eff : cnt_eff + 16'd1;
    cnt_sat     = (cnt_q[vsel_q] == 16'hffff) ? cnt_q[vsel_q] : cnt_q[vsel_q] + 16'd1;
    // note / 12 as (note * 171) >> 11, exact below 128
    note_x171   = 15'(vc.note[6:0]) * 15'd171;
    octave      = note_x171[14:11];
    semi        = 4'(vc.note[6:0] - 7'(octave * 4'd12));
    step_load   = tvcs_pkg::octave_base(semi) << octave;
    last_voice  = vsel_q || !v1_en_q;
    wave_c      = wave_q[vsel_q];
    sweep_c     = sweep_q[vsel_q];
    sweeping    = (sweep_c == tvcs_pkg::SweepDown) || (sweep_c == tvcs_pkg::SweepUp);
  end

  // waveform and noise step
  logic [47:0] ph;
  logic [14:0] lfsr_nx;
  logic        fb;
  logic [3:0]  tri_t;
  logic [15:0] w_mag;
  logic        w_neg;

  always_comb begin
    ph      = phase_q[vsel_q];
    fb      = lfsr_q[vsel_q][0] ^ lfsr_q[vsel_q][1];
    lfsr_nx = {fb, lfsr_q[vsel_q][14:1]};
    if (short_q[vsel_q]) lfsr_nx[6] = fb;
    // triangle step: rises over the first half of the cycle, falls over the second
    tri_t = ph[46:43] ^ {4{ph[47]}};
    w_mag = 16'd32768;
    w_neg = 1'b0;
    if (wave_c == tvcs_pkg::WaveNoise) begin
      w_neg = lfsr_nx[0];
    end else if (wave_c == tvcs_pkg::WaveTri) begin
      w_mag = tvcs_pkg::tri_mag(tri_t);
      w_neg = !tri_t[3];
    end else begin
      case (vc.duty)
        2'd0: begin
          w_neg = (ph[47:45] != 3'd0);
          w_mag = w_neg ? 16'd4681 : 16'd32768;
        end
        2'd1: begin
          w_neg = (ph[47:46] != 2'd0);
          w_mag = w_neg ? 16'd10923 : 16'd32768;
        end
        2'd2: begin
          w_neg = ph[47];
        end
        default: begin
          w_neg = (ph[47:46] == 2'd3);
          w_mag = w_neg ? 16'd32768 : 16'd10923;
        end
      endcase
    end
  end

  // envelope percent times volume
  logic [7:0]  env_steps;
  logic [12:0] env_drop;
  logic [6:0]  pct;
  logic [13:0] amp;

  always_comb begin
    env_steps = prod[39:32];
    env_drop  = 13'(env_steps) * 13'(tvcs_pkg::env_rate(vc.env));
    pct       = (env_drop >= 13'd100) ? 7'd0 : 7'(13'd100 - env_drop);
    amp       = 14'(pct) * 14'(tvcs_pkg::vol_pct(vc.vol));
  end

  // sweep operands and result
  logic [35:0] delta_c;
  logic [63:0] sd, step_cur, step_sw;
  logic [64:0] up_sum;

  always_comb begin
    delta_c  = (sweep_c == tvcs_pkg::SweepDown) ? tvcs_pkg::DownDelta : tvcs_pkg::UpDelta;
    step_cur = step_q[vsel_q];
    sd       = 64'(acc_q[99:48]) + 64'(acc_q[47]);
    up_sum   = {1'b0, step_cur} + {1'b0, sd};
    if (sweep_c == tvcs_pkg::SweepDown) step_sw = step_cur - sd;
    else step_sw = up_sum[64] ? 64'hffff_ffff_ffff_ffff : up_sum[63:0];
  end

  // mix magnitude and final quotient
  logic [16:0] mix_mag;
  logic [18:0] pcm_mag;
  logic [15:0] pcm_clip;
  logic [15:0] voice_q16;

  always_comb begin
    mix_mag   = mix_q[17] ? 17'(-mix_q) : 17'(mix_q);
    pcm_mag   = prod[50:32];
    pcm_clip  = (pcm_mag > 19'(tvcs_pkg::PcmMax)) ? tvcs_pkg::PcmMax : pcm_mag[15:0];
    voice_q16 = prod[60:45];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_PREP: begin
        mul_a = 32'(cnt_eff) * 32'd5;
        mul_b = tvcs_pkg::EnvRecip;
      end
      S_ENV: begin
        mul_a = 32'(w_mag_q);
        mul_b = 32'(amp);
      end
      S_AMP: begin
        mul_a = 32'(prod[28:0] + tvcs_pkg::RndHalf);
        mul_b = tvcs_pkg::RndRecip;
      end
      S_DIV: begin
        mul_a = step_cur[31:0];
        mul_b = delta_c[31:0];
      end
      S_SW1: begin
        mul_a = step_cur[31:0];
        mul_b = 32'(delta_c[35:32]);
      end
      S_SW2: begin
        mul_a = step_cur[63:32];
        mul_b = delta_c[31:0];
      end
      S_SW3: begin
        mul_a = step_cur[63:32];
        mul_b = 32'(delta_c[35:32]);
      end
      S_MIX: begin
        mul_a = 32'(mix_mag);
        mul_b = tvcs_pkg::MixGain;
      end
      S_MIXA: begin
        mul_a = 32'(prod[35:17]);
        mul_b = tvcs_pkg::Div25Recip;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q  <= '{2'd0, 2'd0};
      sweep_q <= '{2'd0, 2'd0};
      short_q <= '{1'b0, 1'b0};
      v1_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tvcs_pkg::RegV0Wave:   wave_q[0]  <= cfg_data_i;
        tvcs_pkg::RegV1Wave:   wave_q[1]  <= cfg_data_i;
        tvcs_pkg::RegV0Sweep:  sweep_q[0] <= cfg_data_i;
        tvcs_pkg::RegV1Sweep:  sweep_q[1] <= cfg_data_i;
        tvcs_pkg::RegV0Short:  short_q[0] <= cfg_data_i[0];
        tvcs_pkg::RegV1Short:  short_q[1] <= cfg_data_i[0];
        tvcs_pkg::RegV1Enable: v1_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // captured item fields (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vin_q[0] <= '{v0_new_note_i, v0_note_i, v0_duty_i, v0_env_i, v0_volume_i};
      vin_q[1] <= '{v1_new_note_i, v1_note_i, v1_duty_i, v1_env_i, v1_volume_i};
    end
  end

  // sequencer and voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vsel_q  <= 1'b0;
      phase_q <= '{48'd0, 48'd0};
      step_q  <= '{64'd0, 64'd0};
      cnt_q   <= '{16'd0, 16'd0};
      lfsr_q  <= '{15'h7fff, 15'h7fff};
      w_mag_q <= '0;
      w_neg_q <= 1'b0;
      mix_q   <= '0;
      acc_q   <= '0;
      pcm_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (effect_start_i) begin
              phase_q <= '{48'd0, 48'd0};
              step_q  <= '{64'd0, 64'd0};
              cnt_q   <= '{16'd0, 16'd0};
              lfsr_q  <= '{15'h7fff, 15'h7fff};
            end
            vsel_q  <= 1'b0;
            mix_q   <= '0;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (vc.note[7]) begin
            // rest: only the counter moves, and a new note clears the step
            cnt_q[vsel_q]  <= cnt_eff_sat;
            step_q[vsel_q] <= step_eff;
            if (last_voice) state_q <= S_MIX;
            else vsel_q <= 1'b1;
          end else begin
            cnt_q[vsel_q]  <= cnt_eff;
            step_q[vsel_q] <= (step_eff == 64'd0) ? step_load : step_eff;
            if (wave_c == tvcs_pkg::WaveNoise) lfsr_q[vsel_q] <= lfsr_nx;
            w_mag_q <= w_mag;
            w_neg_q <= w_neg;
            state_q <= S_ENV;
          end
        end
        S_ENV: state_q <= S_AMP;
        S_AMP: state_q <= S_DIV;
        S_DIV: begin
          mix_q <= w_neg_q ? mix_q - 18'(voice_q16) : mix_q + 18'(voice_q16);
          phase_q[vsel_q] <= phase_q[vsel_q] + step_cur[47:0];
          if (sweeping) begin
            state_q <= S_SW1;
          end else begin
            cnt_q[vsel_q] <= cnt_sat;
            if (last_voice) state_q <= S_MIX;
            else begin
              vsel_q  <= 1'b1;
              state_q <= S_PREP;
            end
          end
        end
        S_SW1: begin
          acc_q   <= 100'(prod);
          state_q <= S_SW2;
        end
        S_SW2: begin
          acc_q   <= acc_q + (100'(prod) << 32);
          state_q <= S_SW3;
        end
        S_SW3: begin
          acc_q   <= acc_q + (100'(prod) << 32);
          state_q <= S_SW4;
        end
        S_SW4: begin
          acc_q   <= acc_q + (100'(prod) << 64);
          state_q <= S_SWFIN;
        end
        S_SWFIN: begin
          step_q[vsel_q] <= step_sw;
          cnt_q[vsel_q]  <= cnt_sat;
          if (last_voice) state_q <= S_MIX;
          else begin
            vsel_q  <= 1'b1;
            state_q <= S_PREP;
          end
        end
        S_MIX:  state_q <= S_MIXA;
        S_MIXA: state_q <= S_MIXB;
        S_MIXB: begin
          pcm_q   <= mix_q[17] ? -$signed(pcm_clip) : $signed(pcm_clip);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/tvcs_mul.sv]
`default_nettype none
// Shared unsigned multiplier, product registered
module tvcs_mul (
  input  wire logic                         clk_i,
  input  wire logic [tvcs_pkg::MulW-1:0]    a_i,
  input  wire logic [tvcs_pkg::MulW-1:0]    b_i,
  output logic      [2*tvcs_pkg::MulW-1:0]  prod_o
);

  logic [2*tvcs_pkg::MulW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;

  // one voice's share of a sample tick
  typedef struct packed {
    logic       new_note;
    logic [7:0] note;
    logic [1:0] duty;
    logic [1:0] env;
    logic [2:0] vol;
  } voice_in_t;

  typedef struct packed {
    logic      effect;
    voice_in_t v1;
    voice_in_t v0;
  } tick_t;

  // Scoreboard: tracks both voices and queues the expected PCM samples
  class synth_scoreboard;
    logic [47:0] phase[2];
    logic [63:0] incr[2];
    int unsigned note_cnt[2];
    logic [14:0] lfsr[2];
    logic [1:0]  wave[2];
    logic [1:0]  sweep[2];
    logic        short_fb[2];
    logic        v1_on;
    logic signed [15:0] pcm_q[$];
    int          errors;

    function new();
      for (int v = 0; v < 2; v++) begin
        phase[v] = '0; incr[v] = '0; note_cnt[v] = 0; lfsr[v] = 15'h7fff;
        wave[v] = '0; sweep[v] = '0; short_fb[v] = 1'b0;
      end
      v1_on = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(tvcs_pkg::reg_idx_e idx, logic [1:0] d);
      case (idx)
        tvcs_pkg::RegV0Wave:   wave[0] = d;
        tvcs_pkg::RegV1Wave:   wave[1] = d;
        tvcs_pkg::RegV0Sweep:  sweep[0] = d;
        tvcs_pkg::RegV1Sweep:  sweep[1] = d;
        tvcs_pkg::RegV0Short:  short_fb[0] = d[0];
        tvcs_pkg::RegV1Short:  short_fb[1] = d[0];
        tvcs_pkg::RegV1Enable: v1_on = d[0];
        default: ;
      endcase
    endfunction

    // nearest, halves away from zero
    function longint div_round(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    // increment of the lowest octave for each semitone
    function logic [63:0] semitone_incr(int unsigned s);
      case (s)
        0: return 64'd104366567318;   1: return 64'd110572526359;
        2: return 64'd117147510927;   3: return 64'd124113464424;
        4: return 64'd131493635070;   5: return 64'd139312653500;
        6: return 64'd147596614960;   7: return 64'd156373166403;
        8: return 64'd165671598752;   9: return 64'd175522944661;
        10: return 64'd185960082081;
        default: return 64'd197017843989;
      endcase
    endfunction

    // round(a*d / 2^48) over the full product, kept to 64 bits
    function logic [63:0] sweep_amount(logic [63:0] a, logic [63:0] d);
      logic [127:0] p;
      p = a * d;
      return p[111:48] + {63'd0, p[47]};
    endfunction

    function longint voice_sample(int v, voice_in_t x);
      int unsigned c, steps, t;
      longint w, pct, amp, s;
      logic [14:0] n;
      logic fb;
      logic [63:0] d;
      if (x.new_note) begin
        note_cnt[v] = 0; incr[v] = '0;
      end
      c = note_cnt[v];
      // rest: only the note counter moves
      if (x.note[7]) begin
        if (c < 65535) note_cnt[v] = c + 1;
        return 0;
      end
      if (incr[v] == 0) incr[v] = semitone_incr(x.note % 12) << (x.note / 12);
      if (wave[v] == tvcs_pkg::WaveNoise) begin
        n = lfsr[v];
        fb = n[0] ^ n[1];
        n = {fb, n[14:1]};
        if (short_fb[v]) n[6] = fb;
        lfsr[v] = n;
        w = n[0] ? -32768 : 32768;
      end else if (wave[v] == tvcs_pkg::WaveTri) begin
        t = phase[v][47:43];
        if (t > 15) t = 31 - t;
        w = div_round((2 * longint'(t) - 15) * 32768, 15);
      end else begin
        case (x.duty)
          2'd0: w = phase[v] < (48'd1 << 45) ? 32768 : -4681;
          2'd1: w = phase[v] < (48'd1 << 46) ? 32768 : -10923;
          2'd2: w = phase[v] < (48'd1 << 47) ? 32768 : -32768;
          default: w = phase[v] < (48'd3 << 46) ? 10923 : -32768;
        endcase
      end
      steps = c * 1000 / 352800;
      pct = 100;
      case (x.env)
        2'd1: pct -= longint'(steps) * 10;
        2'd2: pct -= longint'(steps) * 3;
        2'd3: pct -= longint'(steps) * 25;
        default: ;
      endcase
      if (pct < 0) pct = 0;
      case (x.vol)
        3'd0: amp = pct * 100;
        3'd1: amp = pct * 70;
        3'd2: amp = pct * 60;
        3'd3: amp = pct * 55;
        default: amp = pct * 50;
      endcase
      s = div_round(w * amp, 10000);
      phase[v] = phase[v] + incr[v][47:0];
      // pitch sweep, upward saturating
      if (sweep[v] == tvcs_pkg::SweepDown) begin
        incr[v] = incr[v] - sweep_amount(incr[v], 64'd44237699430);
      end else if (sweep[v] == tvcs_pkg::SweepUp) begin
        d = sweep_amount(incr[v], 64'd20646639365);
        incr[v] = (incr[v] > ~d) ? '1 : incr[v] + d;
      end
      if (c < 65535) note_cnt[v] = c + 1;
      return s;
    endfunction

    function void note_input(tick_t t);
      longint mix, pcm;
      if (t.effect) begin
        for (int v = 0; v < 2; v++) begin
          phase[v] = '0; incr[v] = '0; note_cnt[v] = 0; lfsr[v] = 15'h7fff;
        end
      end
      mix = voice_sample(0, t.v0);
      if (v1_on) mix += voice_sample(1, t.v1);
      pcm = mix * 22 * 32767 / (100 * 32768);
      if (pcm > 32767) pcm = 32767;
      if (pcm < -32767) pcm = -32767;
      pcm_q.push_back(16'(pcm));
    endfunction

    function void check_pcm(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pcm_q.size() == 0) begin
        $error("pcm_sample: no sample expected, got %0d", got);
        errors++;
        return;
      end
      want = pcm_q.pop_front();
      if (got !== want) begin
        $error("pcm_sample: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_stall = 1'b0, cfg_valid = 1'b0;
  logic in_stall, out_valid, cfg_ready;
  tick_t cur = '0;
  tvcs_pkg::reg_idx_e cfg_idx = tvcs_pkg::RegV0Wave;
  logic [1:0] cfg_data = '0;
  logic signed [15:0] pcm;
  int unsigned cycles = 0;
  bit long_hold_req = 1'b0;
  bit quiet_rx = 1'b0;
  synth_scoreboard sb = new();

  // melody state per voice
  voice_in_t mel[2];
  int unsigned mel_left[2] = '{0, 0};
  int unsigned max_hold = 40;

  always #1 clk = ~clk;

  two_voice_chiptune_sample_synth_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .effect_start_i(cur.effect),
    .v0_new_note_i(cur.v0.new_note), .v0_note_i(cur.v0.note),
    .v0_duty_i(cur.v0.duty), .v0_env_i(cur.v0.env), .v0_volume_i(cur.v0.vol),
    .v1_new_note_i(cur.v1.new_note), .v1_note_i(cur.v1.note),
    .v1_duty_i(cur.v1.duty), .v1_env_i(cur.v1.env), .v1_volume_i(cur.v1.vol),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .pcm_sample_o(pcm),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance, or after the random gap
  task automatic send_tick(tick_t t, bit no_gap);
    int unsigned g;
    cur = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
    @(negedge clk);
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(tvcs_pkg::reg_idx_e idx, logic [1:0] d);
    in_valid = 1'b0;
    cfg_idx = idx;
    cfg_data = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // block idle: all samples back plus the worst-case latency
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pcm_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_all(logic [1:0] w0, logic [1:0] w1, logic [1:0] s0, logic [1:0] s1,
                         logic sh0, logic sh1, logic en);
    write_reg(tvcs_pkg::RegV0Wave, w0);
    write_reg(tvcs_pkg::RegV1Wave, w1);
    write_reg(tvcs_pkg::RegV0Sweep, s0);
    write_reg(tvcs_pkg::RegV1Sweep, s1);
    write_reg(tvcs_pkg::RegV0Short, {1'b0, sh0});
    write_reg(tvcs_pkg::RegV1Short, {1'b0, sh1});
    write_reg(tvcs_pkg::RegV1Enable, {1'b0, en});
  endtask

  function voice_in_t voice_dir(logic nn, logic [7:0] nt, logic [1:0] du, logic [1:0] en,
                                logic [2:0] vo);
    voice_in_t x;
    x.new_note = nn; x.note = nt; x.duty = du; x.env = en; x.vol = vo;
    return x;
  endfunction

  // next item of a held-note melody, with some noise items mixed in
  function tick_t melody_tick();
    tick_t t;
    voice_in_t x;
    t = '0;
    if ($urandom_range(0, 99) < 8) begin
      t = tick_t'($urandom());
      return t;
    end
    t.effect = ($urandom_range(0, 99) < 2);
    for (int v = 0; v < 2; v++) begin
      if (mel_left[v] == 0) begin
        x.new_note = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) == 0)
          x.note = 8'($urandom_range(128, 255));
        else if ($urandom_range(0, 3) == 0)
          x.note = 8'($urandom_range(0, 127));
        else
          x.note = 8'($urandom_range(24, 96));
        x.duty = 2'($urandom());
        x.env = 2'($urandom());
        x.vol = 3'($urandom());
        mel[v] = x;
        mel_left[v] = $urandom_range(1, max_hold);
      end else begin
        mel[v].new_note = 1'b0;
      end
      mel_left[v]--;
    end
    t.v0 = mel[0];
    t.v1 = mel[1];
    return t;
  endfunction

  // receiver: random stalls, occasional long hold
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else if (quiet_rx) begin
        out_stall = 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        out_stall = 1'b1;
        hold = $urandom_range(10, 40);
      end else begin
        out_stall = ($urandom_range(0, 99) < 30);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_pcm(pcm);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("FAIL two_voice_chiptune_sample_synth_top");
      $finish;
    end
  end

  initial begin
    bit burst;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes of every field, rests, negative notes, effect start
    set_all(2'd0, 2'd1, 2'd0, 2'd0, 1'b0, 1'b0, 1'b1);
    send_tick({1'b0, voice_dir(1, 8'd0, 0, 0, 0), voice_dir(1, 8'd127, 3, 3, 7)}, 0);
    send_tick({1'b0, voice_dir(0, 8'd127, 1, 1, 1), voice_dir(0, 8'd0, 2, 2, 2)}, 0);
    send_tick({1'b0, voice_dir(1, 8'hff, 2, 2, 3), voice_dir(1, 8'd60, 3, 1, 4)}, 0);
    send_tick({1'b0, voice_dir(0, 8'h80, 3, 3, 4), voice_dir(0, 8'hfe, 0, 3, 5)}, 0);
    send_tick({1'b1, voice_dir(0, 8'd69, 0, 1, 5), voice_dir(0, 8'd45, 1, 2, 6)}, 0);
    for (int i = 0; i < 6; i++)
      send_tick({1'b0, voice_dir(0, 8'd69, 2'(i), 2'(i), 3'(i)),
                 voice_dir(0, 8'd45, 2'(i), 3, 3'(7 - i))}, 0);
    send_tick({1'b1, voice_dir(1, 8'd127, 0, 0, 0), voice_dir(1, 8'hff, 0, 0, 0)}, 0);
    drain();
    // noise with short feedback, wave and sweep code three, second voice off
    set_all(2'd2, 2'd3, 2'd3, 2'd1, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_tick({1'b0, voice_dir(i == 0, 8'd100, 2'(i), 0, 0),
                 voice_dir(i == 0, 8'd30, 3, 0, 0)}, 0);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: set_all(2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        1: set_all(2'd3, 2'd3, 2'd3, 2'd3, 1'b1, 1'b1, 1'b1);
        2: set_all(2'd2, 2'd2, 2'd0, 2'd0, 1'b1, 1'b0, 1'b1);
        3: set_all(2'd1, 2'd0, 2'd2, 2'd2, 1'b0, 1'b0, 1'b1);
        4: set_all(2'd0, 2'd1, 2'd1, 2'd1, 1'b0, 1'b1, 1'b1);
        default: set_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         1'($urandom()), 1'($urandom()), 1'($urandom()));
      endcase
      // upward sweep phase holds notes longer
      max_hold = (ph == 3) ? 300 : 40;
      mel_left[0] = 0;
      mel_left[1] = 0;
      burst = (ph == 4);
      quiet_rx = burst;
      for (int i = 0; i < 95; i++) begin
        if (ph == 2 && i == 10) long_hold_req = 1'b1;
        send_tick(melody_tick(), burst);
      end
      quiet_rx = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pcm_q.size() == 0) begin
      $display("PASS two_voice_chiptune_sample_synth_top");
    end else begin
      $display("FAIL two_voice_chiptune_sample_synth_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
